@@ sv/tdpt_pkg.sv @@
// shared types and constants for the trial division prime test
// used by tdpt_rem, tdpt_ctrl and trial_division_prime_test; depends on nothing
package tdpt_pkg;

    // first candidate divisor, also the smallest prime
    localparam int FIRST_DIVISOR = 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_STEP,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic start;
    } t_rem_req;

    typedef struct packed {
        logic done;
        logic zero;
    } t_rem_rsp;

    typedef struct packed {
        logic valid;
        logic is_prime;
    } t_result;

endpackage

@@ sv/trial_division_prime_test.sv @@
// top level of the trial division prime test: input handshake, output register
// depends on tdpt_pkg, tdpt_rem and tdpt_ctrl

// Tests one unsigned number per beat for primality by trial division and
// returns one beat with is_prime. The number is taken in its low WIDTH bits.
// Candidate divisors run 2, 3, 4, ... while the divisor squared does not
// exceed the number; the square is kept by adding 2d+1 per step, and each
// remainder comes from a bit-serial unit that consumes one dividend bit per
// cycle. An item with a small factor finishes sooner than a prime. One item
// is worked on at a time; the next is accepted as soon as the result has
// moved into the output register, even while that beat is stalled.
module trial_division_prime_test #(
    parameter int WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_number,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_is_prime
);

    localparam int DW = (WIDTH + 1) / 2 + 1;

    logic [63:0]        number_ext;
    logic [WIDTH-1:0]   number_masked;
    logic               idle;
    logic               result_ready;

    logic [WIDTH-1:0]   dividend;
    logic [DW-1:0]      divisor;

    tdpt_pkg::t_rem_req rem_req;
    tdpt_pkg::t_rem_rsp rem_rsp;
    tdpt_pkg::t_result  result;

    logic               r_out_valid;
    logic               r_is_prime;

    assign number_ext    = 64'(i_number);
    assign number_masked = number_ext[WIDTH-1:0];

    tdpt_ctrl #(
        .WIDTH (WIDTH),
        .DW    (DW)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_number       (number_masked),
        .o_idle         (idle),
        .o_rem_req      (rem_req),
        .i_rem_rsp      (rem_rsp),
        .o_dividend     (dividend),
        .o_divisor      (divisor),
        .o_result       (result),
        .i_result_ready (result_ready)
    );

    tdpt_rem #(
        .WIDTH (WIDTH),
        .DW    (DW)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (rem_req),
        .i_dividend (dividend),
        .i_divisor  (divisor),
        .o_rsp      (rem_rsp)
    );

    // output register frees up when empty or when its beat is taken
    assign result_ready = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (result.valid && result_ready) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (result.valid && result_ready) begin
            r_is_prime <= result.is_prime;
        end
    end

    assign o_stall    = !idle;
    assign o_valid    = r_out_valid;
    assign o_is_prime = r_is_prime;

endmodule

@@ sv/tdpt_rem.sv @@
// bit-serial restoring remainder unit: one dividend bit per cycle
// depends on tdpt_pkg for the request and response structs
module tdpt_rem #(
    parameter int WIDTH = 32,
    parameter int DW    = 17
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tdpt_pkg::t_rem_req  i_req,
    input  logic [WIDTH-1:0]    i_dividend,
    input  logic [DW-1:0]       i_divisor,
    output tdpt_pkg::t_rem_rsp  o_rsp
);

    localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    logic [WIDTH-1:0] r_shift;
    logic [DW-1:0]    r_rem;
    logic [CW-1:0]    r_cnt;
    logic             r_run;
    logic             r_done;

    logic [DW:0]      trial;
    logic [DW:0]      divisor_ext;
    logic [DW-1:0]    n_rem;
    logic             last;

    always_comb begin
        trial       = {r_rem, r_shift[WIDTH-1]};
        divisor_ext = {1'b0, i_divisor};
        // trial stays below twice the divisor, so one subtract restores it
        if (trial >= divisor_ext) begin
            n_rem = DW'(trial - divisor_ext);
        end else begin
            n_rem = DW'(trial);
        end
        last = (r_cnt == CW'(WIDTH - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + CW'(1);
                if (last) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_shift <= i_dividend;
            r_rem   <= '0;
        end else if (r_run) begin
            r_shift <= {r_shift[WIDTH-2:0], 1'b0};
            r_rem   <= n_rem;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.zero = (r_rem == '0);

endmodule

@@ sv/tdpt_ctrl.sv @@
// sequencer: holds the number, steps the candidate divisor and its square,
// and runs one serial remainder per candidate; depends on tdpt_pkg
module tdpt_ctrl #(
    parameter int WIDTH = 32,
    parameter int DW    = 17
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [WIDTH-1:0]    i_number,
    output logic                o_idle,
    output tdpt_pkg::t_rem_req  o_rem_req,
    input  tdpt_pkg::t_rem_rsp  i_rem_rsp,
    output logic [WIDTH-1:0]    o_dividend,
    output logic [DW-1:0]       o_divisor,
    output tdpt_pkg::t_result   o_result,
    input  logic                i_result_ready
);

    localparam int SW = WIDTH + 2;

    tdpt_pkg::t_state r_state;
    tdpt_pkg::t_state n_state;

    logic [WIDTH-1:0] r_num;
    logic [DW-1:0]    r_div;
    logic [SW-1:0]    r_sq;
    logic             r_res;

    logic             accept;
    logic             too_small;
    logic             past_bound;

    assign accept     = i_valid && (r_state == tdpt_pkg::ST_IDLE);
    assign too_small  = (r_num < WIDTH'(tdpt_pkg::FIRST_DIVISOR));
    assign past_bound = (r_sq > SW'(r_num));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tdpt_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = tdpt_pkg::ST_CHECK;
                end
            end
            tdpt_pkg::ST_CHECK: begin
                if (too_small || past_bound) begin
                    n_state = tdpt_pkg::ST_DONE;
                end else begin
                    n_state = tdpt_pkg::ST_DIV;
                end
            end
            tdpt_pkg::ST_DIV: begin
                if (i_rem_rsp.done) begin
                    if (i_rem_rsp.zero) begin
                        n_state = tdpt_pkg::ST_DONE;
                    end else begin
                        n_state = tdpt_pkg::ST_STEP;
                    end
                end
            end
            tdpt_pkg::ST_STEP: begin
                n_state = tdpt_pkg::ST_CHECK;
            end
            tdpt_pkg::ST_DONE: begin
                if (i_result_ready) begin
                    n_state = tdpt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tdpt_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_idle            = 1'b0;
        o_rem_req.start   = 1'b0;
        o_result.valid    = 1'b0;
        o_result.is_prime = r_res;
        case (r_state)
            tdpt_pkg::ST_IDLE: begin
                o_idle = 1'b1;
            end
            tdpt_pkg::ST_CHECK: begin
                o_rem_req.start = !(too_small || past_bound);
            end
            tdpt_pkg::ST_DONE: begin
                o_result.valid = 1'b1;
            end
            default: begin
                o_idle = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tdpt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_num <= i_number;
            r_div <= DW'(tdpt_pkg::FIRST_DIVISOR);
            r_sq  <= SW'(tdpt_pkg::FIRST_DIVISOR * tdpt_pkg::FIRST_DIVISOR);
        end
        if (r_state == tdpt_pkg::ST_CHECK) begin
            // zero and one are not prime; otherwise past the bound means prime
            if (too_small) begin
                r_res <= 1'b0;
            end else if (past_bound) begin
                r_res <= 1'b1;
            end
        end
        if ((r_state == tdpt_pkg::ST_DIV) && i_rem_rsp.done && i_rem_rsp.zero) begin
            r_res <= 1'b0;
        end
        if (r_state == tdpt_pkg::ST_STEP) begin
            // (d+1)^2 = d^2 + 2d + 1
            r_div <= r_div + DW'(1);
            r_sq  <= r_sq + SW'({r_div, 1'b1});
        end
    end

    assign o_dividend = r_num;
    assign o_divisor  = r_div;

endmodule

@@ tb/trial_division_prime_test_tb.sv @@
// testbench for trial_division_prime_test: directed and random numbers checked
// against a trial-division predictor; depends on tdpt_pkg and the block's RTL
module trial_division_prime_test_tb;

    localparam int DUT_WIDTH = 32;
    localparam longint unsigned NUMBER_MASK = (64'd1 << DUT_WIDTH) - 64'd1;
    // slowest item here is a prime near 2^20: about 1024 trial divisions
    localparam int STALL_LIMIT = 200_000;
    localparam int SETTLE_CYCLES = 50;
    localparam int IDLE_PERCENT = 31;

    typedef struct packed {
        logic [31:0] number;
        logic        is_prime;
    } t_prime_expect;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [31:0] i_number = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_is_prime;

    t_prime_expect expected_is_prime_q[$];
    bit            idle_enabled = 1'b1;
    int            error_count = 0;
    int            numbers_sent = 0;
    int            results_checked = 0;
    int            primes_seen = 0;
    int            quiet_cycles = 0;

    trial_division_prime_test #(
        .WIDTH(DUT_WIDTH)
    ) u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_number  (i_number),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_is_prime(o_is_prime)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic trial_divide_is_prime(input logic [31:0] raw);
        longint unsigned n;
        longint unsigned d;
        n = raw & NUMBER_MASK;
        if (n < tdpt_pkg::FIRST_DIVISOR) return 1'b0;
        for (d = tdpt_pkg::FIRST_DIVISOR; d <= n / d; d++) begin
            if (n % d == 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    // mostly small numbers so primes stay cheap; wide values carry a small factor
    function automatic logic [31:0] pick_number();
        logic [31:0] factor;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return $urandom_range(0, 32'h0000_FFFF);
            5, 6: return $urandom_range(32'h0001_0000, 32'h000F_FFFF);
            7: return 32'd3 * $urandom_range(0, 32'h5555_5555);
            8: return $urandom & 32'hFFFF_FFFE;
            default: begin
                case ($urandom_range(0, 3))
                    0: factor = 32'd5;
                    1: factor = 32'd7;
                    2: factor = 32'd11;
                    default: factor = 32'd13;
                endcase
                return factor * $urandom_range(0, 32'hFFFF_FFFF / factor);
            end
        endcase
    endfunction

    // one input beat; returns right after the accepting edge with valid still high
    task automatic send_number(input logic [31:0] n);
        @(negedge i_clk);
        while (idle_enabled && $urandom_range(0, 99) < IDLE_PERCENT) begin
            i_valid <= 1'b0;
            i_number <= $urandom;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_number <= n;
        do @(posedge i_clk); while (o_stall);
        expected_is_prime_q.push_back('{number: n, is_prime: trial_divide_is_prime(n)});
        numbers_sent++;
    endtask

    task automatic hold_until_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_is_prime_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_small_values();
        for (int n = 0; n <= 5; n++) send_number(n);
    endtask

    task automatic test_extremes();
        send_number(32'hFFFF_FFFF);
        send_number(32'hFFFF_FFFE);
        send_number(32'h8000_0000);
        send_number(32'h7FFF_FFFE);
        send_number(32'h5555_5555);
        send_number(32'hAAAA_AAAA);
        send_number(32'h0001_0000);
        // squares of primes: the factor sits exactly on the bound; then 2^20 - 3 and 2^20 - 1
        send_number(32'd25);
        send_number(32'd49);
        send_number(32'd63001);
        send_number(32'd1048573);
        send_number(32'd1048575);
    endtask

    task automatic test_pause_until_drained();
        repeat (3) send_number(pick_number());
        hold_until_drained();
        repeat (3) send_number(pick_number());
    endtask

    task automatic test_random_traffic(input int count);
        repeat (count) send_number(pick_number());
    endtask

    task automatic test_back_to_back(input int count);
        idle_enabled = 1'b0;
        repeat (count) send_number(pick_number());
        idle_enabled = 1'b1;
    endtask

    always @(negedge i_clk) begin
        i_stall <= idle_enabled && ($urandom_range(0, 99) < IDLE_PERCENT);
    end

    always @(posedge i_clk) begin
        t_prime_expect want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_is_prime_q.size() == 0) begin
                $display("%0t: result beat is_prime=%0b with nothing expected", $time,
                         o_is_prime);
                error_count++;
            end else begin
                want = expected_is_prime_q.pop_front();
                results_checked++;
                if (o_is_prime) primes_seen++;
                if (o_is_prime !== want.is_prime) begin
                    $display("%0t: is_prime for %0d expected %0b actual %0b", $time,
                             want.number, want.is_prime, o_is_prime);
                    error_count++;
                end
            end
        end
    end

    // no handshake on either side for too long means the block is hung
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_small_values();
        test_extremes();
        test_pause_until_drained();
        test_random_traffic(52);
        test_back_to_back(24);

        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("sent %0d numbers (small, extreme, wide with small factors, random)",
                 numbers_sent);
        $display("checked %0d results, %0d prime, %0d errors", results_checked,
                 primes_seen, error_count);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
